### rtl/lcu_pkg.sv
package lcu_pkg;

  // default shape of the datapath
  localparam int DATA_WIDTH_DEF      = 16;
  localparam int FRAC_BITS_DEF       = 12;
  localparam int ACT_TABLE_DEPTH_DEF = 256;

  // fixed constants of the sigmoid table generator (unsigned q.31)
  localparam logic [63:0] Q31_ONE      = 64'h0000_0000_8000_0000;
  localparam int          SERIES_TERMS = 20;

  // shift-subtract division, only used while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-t in q.31 for t below one, truncated taylor series
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] t);
    longint      acc;
    logic [63:0] term;
    acc  = longint'(Q31_ONE);
    term = Q31_ONE;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = udiv64((term * t) >> 31, 64'(k));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return 64'(acc);
  endfunction

  // sigmoid of a fixed point sample, rounded to fb fraction bits
  function automatic logic [63:0] sig_point(input longint a, input int fb);
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] e1;
    logic [63:0] s;
    logic [63:0] den;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    t   = mag << (31 - fb);
    n   = t >> 31;
    e   = '0;
    if (n < 64'd32) begin
      e  = exp_neg_q31(t & (Q31_ONE - 64'd1));
      e1 = exp_neg_q31(Q31_ONE);
      for (int j = 0; j < 32; j++) begin
        if (64'(j) < n) begin
          e = (e * e1) >> 31;
        end
      end
    end
    den = Q31_ONE + e;
    if (a >= 0) begin
      s = udiv64(Q31_ONE << 31, den);
    end else begin
      s = udiv64(e << 31, den);
    end
    return (s + (64'd1 << (30 - fb))) >> (31 - fb);
  endfunction

endpackage

### rtl/lstm_cell_update_core.sv
// LSTM cell update, forward, one hidden element per beat. Each input beat carries the previous
// cell value and the four gate pre-activations in Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS plus the
// sequence-continue flag in tuser; the result beat carries the saturated new cell and the
// hidden value o*tanh(cell). The block is a 12-stage pipeline that takes a beat every cycle
// while the output is not held off. Sigmoids come from a linearly interpolated table
// of ACT_TABLE_DEPTH+1 points held as constants, tanh is 2*sigmoid(2x)-1. When the output
// is held off the whole pipeline stalls and s_axis_tready drops; nothing is lost.
module lstm_cell_update_core
  import lcu_pkg::*;
#(
  parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int ACT_TABLE_DEPTH = ACT_TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // prev_cell, input_gate_pre, forget_gate_pre, output_gate_pre, candidate_pre
  input  logic [((5*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // seq_continue
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_cell, hidden_out
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int NSTG   = 12;
  localparam int LAT    = 4;
  localparam int OUT_TW = ((2*DATA_WIDTH+7)/8)*8;
  localparam int PW     = DW + FB + 4;

  localparam logic signed [PW-1:0] SMAX = PW'((longint'(1) <<< (DW - 1)) - 1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
  localparam logic signed [PW-1:0] RND  = PW'(longint'(1) <<< (FB - 1));
  localparam logic signed [FB+2:0] ONE3 = (FB+3)'(longint'(1) <<< FB);

  // saturated doubling for the tanh argument
  function automatic logic signed [DW-1:0] sat2(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    if (v[DW-1] != v[DW-2]) begin
      r = v[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = {v[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  // round half up to FB fraction bits, then saturate
  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + RND) >>> FB;
    if (r > SMAX) begin
      return SMAX[DW-1:0];
    end else if (r < SMIN) begin
      return SMIN[DW-1:0];
    end
    return r[DW-1:0];
  endfunction

  // 2*sigmoid - 1
  function automatic logic signed [FB+1:0] to_tanh(input logic [FB:0] s);
    logic signed [FB+2:0] w;
    w = $signed({1'b0, s, 1'b0}) - ONE3;
    return w[FB+1:0];
  endfunction

  logic                 en;
  logic [NSTG-1:0]      vld;

  logic signed [DW-1:0] in_cp;
  logic signed [DW-1:0] in_gi;
  logic signed [DW-1:0] in_gf;
  logic signed [DW-1:0] in_go;
  logic signed [DW-1:0] in_gg;

  logic [FB:0]          sig_i;
  logic [FB:0]          sig_f;
  logic [FB:0]          sig_o;
  logic [FB:0]          sig_g;
  logic [FB:0]          sig_c;

  logic signed [DW-1:0] cp_d   [LAT];
  logic                 flag_d [LAT];
  logic [FB:0]          go_d   [LAT+2];
  logic signed [DW-1:0] cell_d [LAT+1];

  logic [FB:0]           gf_m;
  logic signed [PW-1:0]  pf;
  logic signed [PW-1:0]  pi;
  logic signed [DW-1:0]  cell5;
  logic signed [PW-1:0]  ph;
  logic signed [DW-1:0]  hid;
  logic signed [DW-1:0]  cell_out;

  // global advance: move whenever the output slot is free or drained
  assign en            = !vld[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // unpack the input beat
  assign in_cp = s_axis_tdata[0*DW +: DW];
  assign in_gi = s_axis_tdata[1*DW +: DW];
  assign in_gf = s_axis_tdata[2*DW +: DW];
  assign in_go = s_axis_tdata[3*DW +: DW];
  assign in_gg = s_axis_tdata[4*DW +: DW];

  // gate activations, stages 0..3
  lcu_sig #(.DATA_WIDTH(DW), .FRAC_BITS(FB), .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)) u_sig_i (
    .clk(clk), .en(en), .x(in_gi), .y(sig_i)
  );
  lcu_sig #(.DATA_WIDTH(DW), .FRAC_BITS(FB), .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)) u_sig_f (
    .clk(clk), .en(en), .x(in_gf), .y(sig_f)
  );
  lcu_sig #(.DATA_WIDTH(DW), .FRAC_BITS(FB), .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)) u_sig_o (
    .clk(clk), .en(en), .x(in_go), .y(sig_o)
  );
  lcu_sig #(.DATA_WIDTH(DW), .FRAC_BITS(FB), .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)) u_sig_g (
    .clk(clk), .en(en), .x(sat2(in_gg)), .y(sig_g)
  );

  // previous cell and flag ride along with the activations
  always_ff @(posedge clk) begin
    if (en) begin
      cp_d[0]   <= in_cp;
      flag_d[0] <= s_axis_tuser[0];
      for (int i = 1; i < LAT; i++) begin
        cp_d[i]   <= cp_d[i-1];
        flag_d[i] <= flag_d[i-1];
      end
    end
  end

  // stage 4: the two cell products
  assign gf_m = flag_d[LAT-1] ? sig_f : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      pf      <= PW'($signed({1'b0, gf_m})) * PW'(cp_d[LAT-1]);
      pi      <= PW'($signed({1'b0, sig_i})) * PW'(to_tanh(sig_g));
      go_d[0] <= sig_o;
    end
  end

  // stage 5: new cell
  always_ff @(posedge clk) begin
    if (en) begin
      cell5   <= rnd_sat(pf + pi);
      go_d[1] <= go_d[0];
    end
  end

  // tanh of the new cell, stages 6..9
  lcu_sig #(.DATA_WIDTH(DW), .FRAC_BITS(FB), .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)) u_sig_c (
    .clk(clk), .en(en), .x(sat2(cell5)), .y(sig_c)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cell_d[0] <= cell5;
      for (int i = 1; i <= LAT; i++) begin
        cell_d[i] <= cell_d[i-1];
      end
      for (int i = 2; i < LAT + 2; i++) begin
        go_d[i] <= go_d[i-1];
      end
    end
  end

  // stage 10: output gate product
  always_ff @(posedge clk) begin
    if (en) begin
      ph <= PW'($signed({1'b0, go_d[LAT+1]})) * PW'(to_tanh(sig_c));
    end
  end

  // stage 11: output register
  always_ff @(posedge clk) begin
    if (en) begin
      hid      <= rnd_sat(ph);
      cell_out <= cell_d[LAT];
    end
  end

  assign m_axis_tdata = OUT_TW'({hid, cell_out});

endmodule

### rtl/lcu_sig.sv
// four-stage interpolated sigmoid: index, table read, slope multiply, add
module lcu_sig
  import lcu_pkg::*;
#(
  parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int ACT_TABLE_DEPTH = ACT_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [DATA_WIDTH-1:0] x,
  output logic        [FRAC_BITS:0]   y
);

  localparam int TW = FRAC_BITS + 1;
  localparam int IW = $clog2(ACT_TABLE_DEPTH + 1);

  typedef logic [TW-1:0] tab_t [ACT_TABLE_DEPTH+1];

  // samples evenly spread over the full input range
  function automatic tab_t build_tab();
    tab_t   tab;
    longint xk;
    for (int k = 0; k <= ACT_TABLE_DEPTH; k++) begin
      xk = -(longint'(1) <<< (DATA_WIDTH - 1)) +
           longint'(udiv64(64'(k) << DATA_WIDTH, 64'(ACT_TABLE_DEPTH)));
      tab[k] = TW'(sig_point(xk, FRAC_BITS));
    end
    return tab;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [DATA_WIDTH-1:0]    u;
  logic [DATA_WIDTH+IW-1:0] seg;
  logic [IW-1:0]            idx1;
  logic [DATA_WIDTH-1:0]    frac1;
  logic [TW-1:0]            lo_rd;
  logic [TW-1:0]            hi_rd;
  logic [TW-1:0]            lo2;
  logic [TW-1:0]            delta2;
  logic [DATA_WIDTH-1:0]    frac2;
  logic [TW+DATA_WIDTH-1:0] prod;
  logic [TW-1:0]            lo3;
  logic [TW-1:0]            step3;

  // offset to unsigned and scale to table segments
  assign u   = {~x[DATA_WIDTH-1], x[DATA_WIDTH-2:0]};
  assign seg = (DATA_WIDTH+IW)'(u) * (DATA_WIDTH+IW)'(ACT_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      idx1  <= seg[DATA_WIDTH+IW-1:DATA_WIDTH];
      frac1 <= seg[DATA_WIDTH-1:0];
    end
  end

  // neighbor samples
  assign lo_rd = TAB[idx1];
  assign hi_rd = TAB[idx1 + IW'(1)];

  always_ff @(posedge clk) begin
    if (en) begin
      lo2    <= lo_rd;
      delta2 <= (hi_rd > lo_rd) ? hi_rd - lo_rd : '0;
      frac2  <= frac1;
    end
  end

  // slope times fraction, truncated
  assign prod = (TW+DATA_WIDTH)'(delta2) * (TW+DATA_WIDTH)'(frac2);

  always_ff @(posedge clk) begin
    if (en) begin
      lo3   <= lo2;
      step3 <= prod[TW+DATA_WIDTH-1:DATA_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= lo3 + step3;
    end
  end

endmodule
